/* hdl/pll_divider_search_macros.svh */
// Assertion macros used by the PLL divider search RTL.
`ifndef PLL_DIVIDER_SEARCH_MACROS_SVH
`define PLL_DIVIDER_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pll_divider_search: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pll_divider_search: next-cycle check failed");

`endif

/* hdl/pds_pkg.sv */
// Types and constants shared by the PLL divider search modules.
`default_nettype none

package pds_pkg;

    // Field types at the widths of the ports.
    typedef logic [27:0] freq_t;
    typedef logic [29:0] target_t;
    typedef logic [6:0]  out_div_t;
    typedef logic [6:0]  fb_mult_t;
    typedef logic [3:0]  main_div_t;
    typedef logic [33:0] achieved_t;

    localparam int FREQ_W         = 28;
    localparam int FREQ_RESET     = 100000000;
    localparam int START_ERR      = 32'h7fff_ffff;
    localparam int FB_LOW_FACTOR  = 6;
    localparam int FB_HIGH_FACTOR = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_START,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic md_inc;
        logic fb_init;
        logic fb_inc;
        logic od_inc;
        logic load;
        logic div_start;
        logic eval;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic md_empty;
        logic md_last;
        logic fb_last;
        logic od_last;
        logic exact;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

/* hdl/pds_div.sv */
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none
`include "pll_divider_search_macros.svh"

module pds_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial1;
    logic [DEN_W:0]   trial2;
    logic [DEN_W:0]   diff1;
    logic [DEN_W:0]   diff2;
    logic             ge1;
    logic             ge2;
    logic [DEN_W-1:0] rem1;
    logic [DEN_W-1:0] rem_next;
    logic [QW-1:0]    quo_next;

    // Two restoring steps: each shifts in one numerator bit and subtracts if it can.
    always_comb
    begin
        trial1   = {rem_reg, quo_reg[QW-1]};
        ge1      = trial1 >= {1'b0, den_reg};
        diff1    = trial1 - {1'b0, den_reg};
        rem1     = ge1 ? diff1[DEN_W-1:0] : trial1[DEN_W-1:0];
        trial2   = {rem1, quo_reg[QW-2]};
        ge2      = trial2 >= {1'b0, den_reg};
        diff2    = trial2 - {1'b0, den_reg};
        rem_next = ge2 ? diff2[DEN_W-1:0] : trial2[DEN_W-1:0];
        quo_next = {quo_reg[QW-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= QW'(num);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = NUM_W'(quo_reg);

    `PDS_ASSERT_IMPLY(a_no_restart, clk, rst_n, start, !busy_reg)
    `PDS_ASSERT_IMPLY(a_rem_bound, clk, rst_n, busy_reg, rem_reg < den_reg)
    `PDS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg && !busy_reg)

endmodule

`default_nettype wire

/* hdl/pds_dp.sv */
// Datapath: candidate counters, products, divider, best-candidate tracking and output.
`default_nettype none

module pds_dp #(
    parameter int MAIN_DIV_LIMIT = 10,
    parameter int OUT_DIV_LIMIT  = 128,
    parameter int FB_MULT_MAX    = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pds_pkg::cmd_t      cmd,
    output pds_pkg::status_t        status,
    input  wire logic               cfg_we,
    input  wire pds_pkg::freq_t     cfg_freq,
    input  wire pds_pkg::target_t   target_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pds_pkg::out_div_t       out_div,
    output pds_pkg::fb_mult_t       fb_mult,
    output pds_pkg::main_div_t      main_div,
    output pds_pkg::achieved_t      achieved_hz
);

    localparam int MD_W  = $clog2(MAIN_DIV_LIMIT);
    localparam int OD_W  = $clog2(OUT_DIV_LIMIT);
    localparam int FB_W  = $clog2(FB_MULT_MAX + 1);
    localparam int X_W   = MD_W + FB_W + 4;
    localparam int NUM_W = pds_pkg::FREQ_W + FB_W;
    localparam int DEN_W = MD_W + OD_W;
    localparam int TGT_W = $bits(pds_pkg::target_t);

    pds_pkg::freq_t    freq_reg;
    pds_pkg::target_t  target_reg;
    logic [MD_W-1:0]   md_reg;
    logic [FB_W-1:0]   fb_reg;
    logic [OD_W-1:0]   od_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  best_err_reg;
    logic [NUM_W-1:0]  best_f_reg;
    logic [OD_W-1:0]   best_od_reg;
    logic [FB_W-1:0]   best_fb_reg;
    logic [MD_W-1:0]   best_md_reg;
    logic              out_valid_reg;
    pds_pkg::out_div_t  out_div_reg;
    pds_pkg::fb_mult_t  fb_mult_reg;
    pds_pkg::main_div_t main_div_reg;
    pds_pkg::achieved_t achieved_reg;

    logic [X_W-1:0]    fb_lo_x;
    logic [X_W-1:0]    fb_hi_x;
    logic [FB_W-1:0]   fb_hi;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  tgt_x;
    logic [NUM_W-1:0]  err;
    logic              better;
    logic              div_done;

    // Multiplier range of the current main divider, clipped to the upper bound.
    always_comb
    begin
        fb_lo_x = X_W'(md_reg) * X_W'(pds_pkg::FB_LOW_FACTOR);
        fb_hi_x = X_W'(md_reg) * X_W'(pds_pkg::FB_HIGH_FACTOR);
        if (fb_hi_x > X_W'(FB_MULT_MAX))
            fb_hi = FB_W'(FB_MULT_MAX);
        else
            fb_hi = FB_W'(fb_hi_x);
    end

    always_comb
    begin
        tgt_x  = NUM_W'(target_reg);
        err    = (quot > tgt_x) ? (quot - tgt_x) : (tgt_x - quot);
        better = err < best_err_reg;
    end

    pds_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= pds_pkg::freq_t'(pds_pkg::FREQ_RESET);
            out_valid_reg <= 1'b0;
            md_reg        <= '0;
            fb_reg        <= '0;
            od_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                freq_reg <= cfg_freq;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.start)
                md_reg <= MD_W'(1);
            else if (cmd.md_inc)
                md_reg <= md_reg + 1'b1;
            if (cmd.fb_init)
                fb_reg <= FB_W'(fb_lo_x);
            else if (cmd.fb_inc)
                fb_reg <= fb_reg + 1'b1;
            if (cmd.fb_init || cmd.fb_inc)
                od_reg <= OD_W'(1);
            else if (cmd.od_inc)
                od_reg <= od_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            target_reg <= target_in;
        if (cmd.load)
        begin
            prod_reg <= NUM_W'(freq_reg) * NUM_W'(fb_reg);
            den_reg  <= DEN_W'(md_reg) * DEN_W'(od_reg);
        end
        if (cmd.start)
        begin
            best_err_reg <= NUM_W'(pds_pkg::START_ERR);
            best_f_reg   <= '0;
            best_od_reg  <= '0;
            best_fb_reg  <= '0;
            best_md_reg  <= '0;
        end
        else if (cmd.eval && better)
        begin
            best_err_reg <= err;
            best_f_reg   <= quot;
            best_od_reg  <= od_reg;
            best_fb_reg  <= fb_reg;
            best_md_reg  <= md_reg;
        end
        if (cmd.out_load)
        begin
            out_div_reg  <= pds_pkg::out_div_t'(best_od_reg);
            fb_mult_reg  <= pds_pkg::fb_mult_t'(best_fb_reg);
            main_div_reg <= pds_pkg::main_div_t'(best_md_reg);
            achieved_reg <= pds_pkg::achieved_t'(best_f_reg);
        end
    end

    always_comb
    begin
        status.md_empty = fb_lo_x > X_W'(FB_MULT_MAX);
        status.md_last  = md_reg == MD_W'(MAIN_DIV_LIMIT - 1);
        status.fb_last  = fb_reg == fb_hi;
        status.od_last  = od_reg == OD_W'(OUT_DIV_LIMIT - 1);
        status.exact    = quot == tgt_x;
        status.div_done = div_done;
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_div     = out_div_reg;
    assign fb_mult     = fb_mult_reg;
    assign main_div    = main_div_reg;
    assign achieved_hz = achieved_reg;

    // The target field is narrower than the quotient, so the error compare is sound.
    if (TGT_W > NUM_W)
    begin : g_width_check
        $error("target wider than quotient");
    end

endmodule

`default_nettype wire

/* hdl/pds_ctrl.sv */
// Controller state machine that sequences the candidate search.
`default_nettype none

module pds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pds_pkg::status_t  status,
    output pds_pkg::cmd_t          cmd
);

    pds_pkg::state_t state_reg;
    pds_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = pds_pkg::ST_SETUP;
                end
            end
            pds_pkg::ST_SETUP:
            begin
                priority if (!status.md_empty)
                begin
                    cmd.fb_init = 1'b1;
                    state_next  = pds_pkg::ST_LOAD;
                end
                else if (status.md_last)
                    state_next = pds_pkg::ST_FINISH;
                else
                    cmd.md_inc = 1'b1;
            end
            pds_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = pds_pkg::ST_START;
            end
            pds_pkg::ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = pds_pkg::ST_DIV;
            end
            pds_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = pds_pkg::ST_EVAL;
            end
            pds_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (status.exact)
                    state_next = pds_pkg::ST_FINISH;
                else if (!status.od_last)
                begin
                    cmd.od_inc = 1'b1;
                    state_next = pds_pkg::ST_LOAD;
                end
                else if (!status.fb_last)
                begin
                    cmd.fb_inc = 1'b1;
                    state_next = pds_pkg::ST_LOAD;
                end
                else if (!status.md_last)
                begin
                    cmd.md_inc = 1'b1;
                    state_next = pds_pkg::ST_SETUP;
                end
                else
                    state_next = pds_pkg::ST_FINISH;
            end
            pds_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/pll_divider_search.sv */
// Top level of the PLL divider search block.
`default_nettype none

// PLL divider search. Each beat on the input channel carries a requested
// output frequency in Hz. The block walks every PLL setting in a fixed
// order: main divider from 1 to MAIN_DIV_LIMIT-1, then feedback multiplier
// from 6 times the main divider up to 12 times it or FB_MULT_MAX, whichever
// is lower, then output divider from 1 to OUT_DIV_LIMIT-1. For each setting
// it forms reference * multiplier / (main divider * output divider), with
// truncating division and no overflow, and keeps the first setting whose
// error against the target is strictly smallest. An exact match ends the
// search at once. One beat on the output channel returns the chosen dividers
// and the frequency they give. Each setting is a product load, a pass
// through the shared divider, which retires two quotient bits per cycle,
// and a compare. With the default limits there are 22225 settings; an
// exact match finishes sooner. One request is searched at a time; a new
// request is taken while the previous result still waits in the output
// register. The reference frequency is written through the configuration
// channel, which is always ready and must only be used while no search is
// running; it resets to 100 MHz.
module pll_divider_search #(
    parameter int MAIN_DIV_LIMIT = 10,
    parameter int OUT_DIV_LIMIT  = 128,
    parameter int FB_MULT_MAX    = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire pds_pkg::freq_t      input_freq_hz,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pds_pkg::target_t    target_hz,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pds_pkg::out_div_t        out_div,
    output pds_pkg::fb_mult_t        fb_mult,
    output pds_pkg::main_div_t       main_div,
    output pds_pkg::achieved_t       achieved_hz
);

    pds_pkg::cmd_t    cmd;
    pds_pkg::status_t status;

    // The reference frequency register takes every write, so the port never stalls.
    assign cfg_ready = 1'b1;

    pds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pds_dp #(
        .MAIN_DIV_LIMIT (MAIN_DIV_LIMIT),
        .OUT_DIV_LIMIT  (OUT_DIV_LIMIT),
        .FB_MULT_MAX    (FB_MULT_MAX)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid),
        .cfg_freq    (input_freq_hz),
        .target_in   (target_hz),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_div     (out_div),
        .fb_mult     (fb_mult),
        .main_div    (main_div),
        .achieved_hz (achieved_hz)
    );

endmodule

`default_nettype wire
